@@ rtl/sne_pkg.sv @@
// Shared types and constants for the sawtooth note envelope mixer.
// Used by sne_ctrl, sne_dp and sawtooth_note_envelope_mixer; depends on nothing.
package sne_pkg;

    // Default widths of the voice phase and of the note length counter.
    localparam int PHASE_BITS_DEF  = 24;
    localparam int LENGTH_BITS_DEF = 24;

    // Fixed widths of the stream fields.
    localparam int LEN_IN_W  = 24;
    localparam int POS_W     = 26;
    localparam int STEP_IN_W = 24;
    localparam int SAMPLE_W  = 16;
    localparam int RAMP_W    = 16;
    localparam int AMP_W     = 15;
    localparam int SAW_W     = 16;

    // Slave-side tdata layout, lowest field first, padded to whole bytes.
    localparam int LEN_LSB   = 0;
    localparam int POS_LSB   = LEN_LSB + LEN_IN_W;
    localparam int STEPA_LSB = POS_LSB + POS_W;
    localparam int STEPB_LSB = STEPA_LSB + STEP_IN_W;
    localparam int DUAL_LSB  = STEPB_LSB + STEP_IN_W;
    localparam int EXIST_LSB = DUAL_LSB + 1;
    localparam int IN_BITS   = EXIST_LSB + SAMPLE_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = SAMPLE_W;

    // The envelope quotient never exceeds the amplitude, so one step per amplitude bit.
    localparam int DIV_STEPS = AMP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operation codes carried in tuser.
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AMP_ONE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AMP_TWO = 2'd3;
    localparam int CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [RAMP_W-1:0] ATTACK_RST  = 16'd441;
    localparam logic [RAMP_W-1:0] RELEASE_RST = 16'd441;
    localparam logic [AMP_W-1:0]  AMP_ONE_RST = 15'd8191;
    localparam logic [AMP_W-1:0]  AMP_TWO_RST = 15'd4095;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_note;    // capture the fields of a start transfer
        logic load_sample;  // capture the existing sample
        logic mul_phase_a;  // phase_a = position * step_a
        logic mul_phase_b;  // phase_b = position * step_b
        logic env_setup;    // pick ramp, form amplitude product, seed divider
        logic div_step;     // one restoring division step
        logic mix;          // envelope times voice sum
        logic commit;       // write the result and advance the note
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic note_active;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/sne_ctrl.sv @@
// Controller state machine of the sawtooth note envelope mixer.
// Depends on sne_pkg; drives the command struct of sne_dp.
module sne_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_op,
    input  sne_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output sne_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PHA  = 7'b0000010,
        S_PHB  = 7'b0000100,
        S_ENV  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_MIX  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [sne_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                            w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    // Next state, step counter and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == sne_pkg::OP_START) begin
                        o_cmd.load_note = 1'b1;
                        n_state = S_PHA;
                    end else if (i_sts.note_active) begin
                        o_cmd.load_sample = 1'b1;
                        n_state = S_ENV;
                    end
                end
            end
            S_PHA: begin
                o_cmd.mul_phase_a = 1'b1;
                n_state = S_PHB;
            end
            S_PHB: begin
                o_cmd.mul_phase_b = 1'b1;
                n_state = S_IDLE;
            end
            S_ENV: begin
                o_cmd.env_setup = 1'b1;
                n_cnt   = sne_pkg::DIV_CNT_W'(sne_pkg::DIV_STEPS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold here while the previous result still waits.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ rtl/sne_dp.sv @@
// Datapath of the sawtooth note envelope mixer: configuration, note state,
// phase multiplier, envelope divider, mixing and output register. Depends on sne_pkg.
module sne_dp #(
    parameter int PHASE_BITS  = sne_pkg::PHASE_BITS_DEF,
    parameter int LENGTH_BITS = sne_pkg::LENGTH_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sne_pkg::t_cmd                        i_cmd,
    output sne_pkg::t_sts                        o_sts,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [sne_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [sne_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // Input fields
    input  logic [sne_pkg::LEN_IN_W-1:0]         i_note_length,
    input  logic [sne_pkg::POS_W-1:0]            i_start_position,
    input  logic [sne_pkg::STEP_IN_W-1:0]        i_phase_step_a,
    input  logic [sne_pkg::STEP_IN_W-1:0]        i_phase_step_b,
    input  logic                                 i_two_voices,
    input  logic signed [sne_pkg::SAMPLE_W-1:0]  i_existing_sample,
    // Result register
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [sne_pkg::SAMPLE_W-1:0]  o_mixed_sample,
    output logic                                 o_last_sample
);

    localparam int PROD_W  = sne_pkg::AMP_W + sne_pkg::RAMP_W;
    localparam int SUM_W   = sne_pkg::SAW_W + 1;
    localparam int MIX_W   = sne_pkg::AMP_W + 1 + SUM_W;
    localparam int TOTAL_W = MIX_W + 1;
    localparam int SHIFT   = sne_pkg::SAMPLE_W - 1;
    localparam int WIDE_W  = TOTAL_W - SHIFT;
    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(32767);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(32768);
    localparam int POS_W_PLUS = sne_pkg::POS_W + PHASE_BITS;

    // Configuration registers.
    logic [sne_pkg::RAMP_W-1:0] r_attack, r_release;
    logic [sne_pkg::AMP_W-1:0]  r_amp_one, r_amp_two;

    // Note state.
    logic [sne_pkg::POS_W-1:0]  r_pos;
    logic [PHASE_BITS-1:0]      r_step_a, r_step_b, r_phase_a, r_phase_b;
    logic [LENGTH_BITS-1:0]     r_len, r_idx;
    logic                       r_dual, r_active;

    // Sample work registers.
    logic signed [sne_pkg::SAMPLE_W-1:0] r_exist;
    logic                                r_ramp;
    logic [sne_pkg::AMP_W-1:0]           r_amp_sel, r_quo;
    logic [sne_pkg::RAMP_W-1:0]          r_divisor, r_rem;
    logic [sne_pkg::AMP_W-1:0]           r_num_lo;
    logic signed [MIX_W-1:0]             r_mix;

    // Result register.
    logic                                r_out_valid, r_out_last;
    logic signed [sne_pkg::SAMPLE_W-1:0] r_out_data;

    logic [POS_W_PLUS-1:0]               w_phase_prod;

    logic [LENGTH_BITS-1:0]         w_left;
    logic                           w_att_ramp, w_rel_ramp, w_last;
    logic [sne_pkg::RAMP_W-1:0]     w_mul_x, w_divisor;
    logic [sne_pkg::AMP_W-1:0]      w_amp, w_env;
    logic [PROD_W-1:0]              w_env_prod;
    logic [sne_pkg::RAMP_W+1:0]     w_trial;
    logic signed [sne_pkg::SAW_W-1:0] w_saw_a, w_saw_b;
    logic signed [SUM_W-1:0]        w_sum;
    logic signed [TOTAL_W-1:0]      w_total;
    logic signed [WIDE_W-1:0]       w_wide;
    logic signed [sne_pkg::SAMPLE_W-1:0] w_sat;

    assign o_sts.note_active = r_active;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_mixed_sample    = r_out_data;
    assign o_last_sample     = r_out_last;

    // Start phase product; one multiplier serves both voices in turn.
    assign w_phase_prod = POS_W_PLUS'(r_pos) *
                          POS_W_PLUS'(i_cmd.mul_phase_b ? r_step_b : r_step_a);

    // Envelope selection: attack ramp first, then release ramp, else flat.
    always_comb begin
        w_left     = r_len - r_idx;
        w_att_ramp = (r_attack != '0) && (r_idx < LENGTH_BITS'(r_attack));
        w_rel_ramp = (r_release != '0) && (w_left < LENGTH_BITS'(r_release));
        w_mul_x    = w_att_ramp ? r_idx[sne_pkg::RAMP_W-1:0] : w_left[sne_pkg::RAMP_W-1:0];
        w_divisor  = w_att_ramp ? r_attack : r_release;
        w_amp      = r_dual ? r_amp_two : r_amp_one;
        w_env_prod = PROD_W'(w_amp) * PROD_W'(w_mul_x);
        w_last     = (w_left == LENGTH_BITS'(1));
    end

    // One restoring division step: bring down the next numerator bit and try the divisor.
    assign w_trial = {1'b0, r_rem, r_num_lo[sne_pkg::AMP_W-1]} - {2'b00, r_divisor};

    // Sawtooth values, voice sum and envelope.
    always_comb begin
        w_saw_a = $signed(r_phase_a[PHASE_BITS-1 -: sne_pkg::SAW_W]);
        w_saw_b = $signed(r_phase_b[PHASE_BITS-1 -: sne_pkg::SAW_W]);
        w_sum   = SUM_W'(w_saw_a) + (r_dual ? SUM_W'(w_saw_b) : SUM_W'(0));
        w_env   = r_ramp ? r_quo : r_amp_sel;
    end

    // Mix with the existing sample, floor by the Q15 scale and saturate.
    always_comb begin
        w_total = $signed({r_exist, SHIFT'(0)}) + TOTAL_W'(r_mix);
        w_wide  = w_total[TOTAL_W-1:SHIFT];
        if (w_wide > SAT_MAX) begin
            w_sat = sne_pkg::SAMPLE_W'(SAT_MAX);
        end else if (w_wide < SAT_MIN) begin
            w_sat = sne_pkg::SAMPLE_W'(SAT_MIN);
        end else begin
            w_sat = w_wide[sne_pkg::SAMPLE_W-1:0];
        end
    end

    // Configuration registers and note activity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= sne_pkg::ATTACK_RST;
            r_release <= sne_pkg::RELEASE_RST;
            r_amp_one <= sne_pkg::AMP_ONE_RST;
            r_amp_two <= sne_pkg::AMP_TWO_RST;
            r_active  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    sne_pkg::REG_ATTACK:  r_attack  <= i_cfg_wdata;
                    sne_pkg::REG_RELEASE: r_release <= i_cfg_wdata;
                    sne_pkg::REG_AMP_ONE: r_amp_one <= i_cfg_wdata[sne_pkg::AMP_W-1:0];
                    sne_pkg::REG_AMP_TWO: r_amp_two <= i_cfg_wdata[sne_pkg::AMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_note) begin
                r_active <= (LENGTH_BITS'(i_note_length) != '0);
            end else if (i_cmd.commit && w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // Note state: loaded on a start, advanced once per delivered sample.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_note) begin
            r_pos    <= i_start_position;
            r_step_a <= PHASE_BITS'(i_phase_step_a);
            r_step_b <= PHASE_BITS'(i_phase_step_b);
            r_len    <= LENGTH_BITS'(i_note_length);
            r_dual   <= i_two_voices;
            r_idx    <= '0;
        end
        if (i_cmd.mul_phase_a) begin
            r_phase_a <= w_phase_prod[PHASE_BITS-1:0];
        end
        if (i_cmd.mul_phase_b) begin
            r_phase_b <= w_phase_prod[PHASE_BITS-1:0];
        end
        if (i_cmd.commit) begin
            r_phase_a <= r_phase_a + r_step_a;
            r_phase_b <= r_phase_b + r_step_b;
            r_idx     <= r_idx + 1'b1;
        end
    end

    // Envelope product, divider and mixing product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_exist <= i_existing_sample;
        end
        if (i_cmd.env_setup) begin
            r_ramp    <= w_att_ramp || w_rel_ramp;
            r_amp_sel <= w_amp;
            r_divisor <= w_divisor;
            r_rem     <= w_env_prod[PROD_W-1:sne_pkg::AMP_W];
            r_num_lo  <= w_env_prod[sne_pkg::AMP_W-1:0];
            r_quo     <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_trial[sne_pkg::RAMP_W+1]) begin
                r_rem <= w_trial[sne_pkg::RAMP_W-1:0];
            end else begin
                r_rem <= {r_rem[sne_pkg::RAMP_W-2:0], r_num_lo[sne_pkg::AMP_W-1]};
            end
            r_num_lo <= {r_num_lo[sne_pkg::AMP_W-2:0], 1'b0};
            r_quo    <= {r_quo[sne_pkg::AMP_W-2:0], !w_trial[sne_pkg::RAMP_W+1]};
        end
        if (i_cmd.mix) begin
            r_mix <= $signed({1'b0, w_env}) * w_sum;
        end
    end

    // Result register; the next item may be accepted while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= w_sat;
            r_out_last <= w_last;
        end
    end

endmodule

@@ rtl/sawtooth_note_envelope_mixer.sv @@
// Top level of the sawtooth note envelope mixer: stream ports, controller and datapath.
// Depends on sne_pkg, sne_ctrl and sne_dp.
//
//  Channel   Direction  Signals                          Transfer carries
//  s_axis    in         tvalid tready tdata tuser        start note or one sample to mix
//  m_axis    out        tvalid tready tdata tlast        mixed sample, last-of-note flag
//  cfg       in         i_cfg_we i_cfg_addr i_cfg_wdata  register write, no read-back
//
// A start transfer is accepted and then uses the shared phase multiplier once per
// voice, voice A then voice B. A sample transfer steps through accept, envelope
// product, 15 steps of the restoring envelope divider, mix product, output write.
// A sample transfer with no note active is accepted and gives no result.
// The output write waits while the previous result is still not taken.
// Reset is synchronous; there is no clearing pass.
module sawtooth_note_envelope_mixer #(
    parameter int PHASE_BITS  = sne_pkg::PHASE_BITS_DEF,
    parameter int LENGTH_BITS = sne_pkg::LENGTH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Fields from bit 0 up: note_length[23:0], start_position[49:24],
    // phase_step_a[73:50], phase_step_b[97:74], two_voices[98],
    // existing_sample[114:99], zero fill[119:115].
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sne_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // Fields: op[0] (start note or next sample).
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields: mixed_sample[15:0].
    output logic [sne_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [sne_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sne_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    sne_pkg::t_cmd                        w_cmd;
    sne_pkg::t_sts                        w_sts;
    logic signed [sne_pkg::SAMPLE_W-1:0]  w_existing;
    logic signed [sne_pkg::SAMPLE_W-1:0]  w_mixed;

    assign w_existing   = $signed(s_axis_tdata[sne_pkg::EXIST_LSB +: sne_pkg::SAMPLE_W]);
    assign m_axis_tdata = w_mixed;

    // Sequencer for start and sample transfers.
    sne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and state.
    sne_dp #(
        .PHASE_BITS  (PHASE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_note_length     (s_axis_tdata[sne_pkg::LEN_LSB +: sne_pkg::LEN_IN_W]),
        .i_start_position  (s_axis_tdata[sne_pkg::POS_LSB +: sne_pkg::POS_W]),
        .i_phase_step_a    (s_axis_tdata[sne_pkg::STEPA_LSB +: sne_pkg::STEP_IN_W]),
        .i_phase_step_b    (s_axis_tdata[sne_pkg::STEPB_LSB +: sne_pkg::STEP_IN_W]),
        .i_two_voices      (s_axis_tdata[sne_pkg::DUAL_LSB]),
        .i_existing_sample (w_existing),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_mixed_sample    (w_mixed),
        .o_last_sample     (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // The controller issues at most one command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    // A sample transfer on an active note closes the input until its result is written.
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == sne_pkg::OP_SAMPLE)
         && w_sts.note_active) |=> !s_axis_tready)
        else $error("input accepted while a sample is in work");

    // A result appears only from a commit.
    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.commit))
        else $error("output valid without a commit");

    // A start transfer never produces a result in the next cycle.
    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == sne_pkg::OP_START))
        |=> !w_cmd.commit)
        else $error("commit after a start transfer");
`endif

endmodule
